// ===== sv/servo_pwm_with_slew_ramp_macros.svh =====
// Assertion macros shared by the servo PWM RTL.
`ifndef SERVO_PWM_WITH_SLEW_RAMP_MACROS_SVH
`define SERVO_PWM_WITH_SLEW_RAMP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/spwm_pkg.sv =====
// Package: types and constants of the servo PWM block.
`timescale 1ns / 1ps
package spwm_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_SET_ANGLE = 2'd1;
	localparam logic [1:0] OP_HUMIDITY  = 2'd2;

	localparam logic [2:0] REG_MIN_PULSE     = 3'd0;
	localparam logic [2:0] REG_MAX_PULSE     = 3'd1;
	localparam logic [2:0] REG_FRAME_PERIOD  = 3'd2;
	localparam logic [2:0] REG_RAMP_INTERVAL = 3'd3;
	localparam logic [2:0] REG_RAMP_STEP     = 3'd4;
	localparam logic [2:0] REG_OPEN_ANGLE    = 3'd5;
	localparam logic [2:0] REG_CLOSED_ANGLE  = 3'd6;
	localparam logic [2:0] REG_HUM_THRESH    = 3'd7;

	localparam logic [11:0] MIN_PULSE_RST     = 12'd620;
	localparam logic [11:0] MAX_PULSE_RST     = 12'd2250;
	localparam logic [15:0] FRAME_PERIOD_RST  = 16'd20000;
	localparam logic [15:0] RAMP_INTERVAL_RST = 16'd15000;
	localparam logic [7:0]  RAMP_STEP_RST     = 8'd5;
	localparam logic [6:0]  OPEN_ANGLE_RST    = 7'd100;
	localparam logic [6:0]  CLOSED_ANGLE_RST  = 7'd0;
	localparam logic [9:0]  HUM_THRESH_RST    = 10'd750;
	localparam logic [11:0] WIDTH_RST         = 12'd620;

	localparam logic [6:0]  ANGLE_FULL   = 7'd100;
	localparam logic [15:0] COUNTER_MAX  = 16'hFFFF;
	// floor(v/100) = (v * ceil(2^32/100)) >> 32, exact for v < 2^19
	localparam logic [25:0] DIV100_RECIP = 26'd42949673;
	localparam logic [18:0] DIV100_ROUND = 19'd99;

	typedef struct packed {
		logic [11:0] min_pulse;
		logic [11:0] max_pulse;
		logic [15:0] frame_period;
		logic [15:0] ramp_interval;
		logic [7:0]  ramp_step;
		logic [6:0]  open_angle;
		logic [6:0]  closed_angle;
		logic [9:0]  hum_thresh;
	} spwm_cfg_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         op;
		logic               hum_ge;
		logic signed [19:0] prod;
	} spwm_prod_t;

endpackage

// ===== sv/spwm_regs.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module spwm_regs
	import spwm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output spwm_cfg_t         cfg
);

	spwm_cfg_t  cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse     <= MIN_PULSE_RST;
			cfg_q.max_pulse     <= MAX_PULSE_RST;
			cfg_q.frame_period  <= FRAME_PERIOD_RST;
			cfg_q.ramp_interval <= RAMP_INTERVAL_RST;
			cfg_q.ramp_step     <= RAMP_STEP_RST;
			cfg_q.open_angle    <= OPEN_ANGLE_RST;
			cfg_q.closed_angle  <= CLOSED_ANGLE_RST;
			cfg_q.hum_thresh    <= HUM_THRESH_RST;
		end else if (wr) begin
			case (idx)
				REG_MIN_PULSE:     cfg_q.min_pulse     <= pwdata[11:0];
				REG_MAX_PULSE:     cfg_q.max_pulse     <= pwdata[11:0];
				REG_FRAME_PERIOD:  cfg_q.frame_period  <= pwdata[15:0];
				REG_RAMP_INTERVAL: cfg_q.ramp_interval <= pwdata[15:0];
				REG_RAMP_STEP:     cfg_q.ramp_step     <= pwdata[7:0];
				REG_OPEN_ANGLE:    cfg_q.open_angle    <= pwdata[6:0];
				REG_CLOSED_ANGLE:  cfg_q.closed_angle  <= pwdata[6:0];
				REG_HUM_THRESH:    cfg_q.hum_thresh    <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_PULSE:     prdata = {20'd0, cfg_q.min_pulse};
			REG_MAX_PULSE:     prdata = {20'd0, cfg_q.max_pulse};
			REG_FRAME_PERIOD:  prdata = {16'd0, cfg_q.frame_period};
			REG_RAMP_INTERVAL: prdata = {16'd0, cfg_q.ramp_interval};
			REG_RAMP_STEP:     prdata = {24'd0, cfg_q.ramp_step};
			REG_OPEN_ANGLE:    prdata = {25'd0, cfg_q.open_angle};
			REG_CLOSED_ANGLE:  prdata = {25'd0, cfg_q.closed_angle};
			REG_HUM_THRESH:    prdata = {22'd0, cfg_q.hum_thresh};
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== sv/spwm_target.sv =====
// Stage 2: angle selection, clamp and (100-angle)*(max-min) product.
`timescale 1ns / 1ps
module spwm_target
	import spwm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       valid_s1,
	input  logic [1:0] op_s1,
	input  logic [7:0] angle_s1,
	input  logic [9:0] humidity_s1,
	input  spwm_cfg_t  cfg,
	output spwm_prod_t prod_s2
);

	logic               hum_ge;
	logic [7:0]         sel_angle;
	logic [6:0]         clamped;
	logic [6:0]         span;
	logic signed [12:0] diff;
	logic signed [19:0] prod;

	// the open angle applies at or above the threshold, whatever the lid state
	assign hum_ge    = humidity_s1 >= cfg.hum_thresh;
	assign sel_angle = (op_s1 == OP_SET_ANGLE) ? angle_s1 :
		{1'b0, (hum_ge ? cfg.open_angle : cfg.closed_angle)};
	assign clamped   = (sel_angle > {1'b0, ANGLE_FULL}) ? ANGLE_FULL : sel_angle[6:0];
	assign span      = ANGLE_FULL - clamped;
	assign diff      = $signed({1'b0, cfg.max_pulse}) - $signed({1'b0, cfg.min_pulse});
	assign prod      = $signed({13'd0, span}) * 20'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s2 <= '0;
		end else if (load) begin
			prod_s2.valid <= valid_s1;
			if (valid_s1) begin
				prod_s2.op     <= op_s1;
				prod_s2.hum_ge <= hum_ge;
				prod_s2.prod   <= prod;
			end
		end
	end

endmodule

// ===== sv/spwm_state.sv =====
// Stage 3: target divide, lid control, ramp and pin timing; holds the result.
`timescale 1ns / 1ps
`include "servo_pwm_with_slew_ramp_macros.svh"
module spwm_state
	import spwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  spwm_prod_t  prod_s2,
	input  spwm_cfg_t   cfg,
	output logic        out_valid,
	output logic        pin_level,
	output logic [11:0] pulse_width_us,
	output logic        lid_open
);

	logic        out_valid_q;
	logic [11:0] cur_q, tgt_q;
	logic        pin_q, lid_q;
	logic [15:0] phase_q, ramp_q;

	logic [11:0] cur_nx, tgt_nx;
	logic        pin_nx, lid_nx;
	logic [15:0] phase_nx, ramp_nx;

	logic        upd, is_tick;
	logic        neg;
	logic [18:0] mag, dividend;
	logic [44:0] qprod;
	logic [11:0] quot, offs, new_tgt;

	logic [15:0] ramp_bump, phase_bump, wait_us;
	logic [12:0] sum_up, lim_dn;
	logic [11:0] cur_ramp;
	logic        step_hit, toggle;

	assign upd     = load && prod_s2.valid;
	assign is_tick = prod_s2.op == OP_TICK;

	// floor((100-a)*(max-min)/100), rounding toward minus infinity
	assign neg      = prod_s2.prod[19];
	assign mag      = neg ? 19'(-prod_s2.prod) : prod_s2.prod[18:0];
	assign dividend = mag + (neg ? DIV100_ROUND : 19'd0);
	assign qprod    = dividend * DIV100_RECIP;
	assign quot     = qprod[43:32];
	assign offs     = neg ? (12'd0 - quot) : quot;
	assign new_tgt  = cfg.min_pulse + offs;

	assign ramp_bump = (ramp_q == COUNTER_MAX) ? ramp_q : ramp_q + 16'd1;
	assign step_hit  = ramp_bump >= cfg.ramp_interval;
	assign sum_up    = {1'b0, cur_q} + {5'd0, cfg.ramp_step};
	assign lim_dn    = {1'b0, tgt_q} + {5'd0, cfg.ramp_step};

	always_comb begin
		if (!step_hit) begin
			cur_ramp = cur_q;
		end else if (cur_q < tgt_q) begin
			cur_ramp = (sum_up > {1'b0, tgt_q}) ? tgt_q : sum_up[11:0];
		end else if (cur_q > tgt_q) begin
			cur_ramp = ({1'b0, cur_q} < lim_dn) ? tgt_q : cur_q - {4'd0, cfg.ramp_step};
		end else begin
			cur_ramp = cur_q;
		end
	end

	assign phase_bump = (phase_q == COUNTER_MAX) ? phase_q : phase_q + 16'd1;
	assign wait_us    = pin_q ? {4'd0, cur_ramp} :
		((cfg.frame_period > {4'd0, cur_ramp}) ? cfg.frame_period - {4'd0, cur_ramp} : 16'd0);
	assign toggle     = phase_bump >= wait_us;

	always_comb begin
		cur_nx   = cur_q;
		tgt_nx   = tgt_q;
		pin_nx   = pin_q;
		lid_nx   = lid_q;
		phase_nx = phase_q;
		ramp_nx  = ramp_q;
		case (prod_s2.op)
			OP_TICK: begin
				cur_nx   = cur_ramp;
				ramp_nx  = step_hit ? 16'd0 : ramp_bump;
				pin_nx   = toggle ? !pin_q : pin_q;
				phase_nx = toggle ? 16'd0 : phase_bump;
			end
			OP_SET_ANGLE: begin
				tgt_nx = new_tgt;
			end
			OP_HUMIDITY: begin
				if (prod_s2.hum_ge != lid_q) begin
					lid_nx = prod_s2.hum_ge;
					tgt_nx = new_tgt;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_q       <= WIDTH_RST;
			tgt_q       <= WIDTH_RST;
			pin_q       <= 1'b0;
			lid_q       <= 1'b0;
			phase_q     <= '0;
			ramp_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= prod_s2.valid;
			end
			if (upd) begin
				cur_q   <= cur_nx;
				tgt_q   <= tgt_nx;
				pin_q   <= pin_nx;
				lid_q   <= lid_nx;
				phase_q <= phase_nx;
				ramp_q  <= ramp_nx;
			end
		end
	end

	// state doubles as the result register: it only moves when a result is loaded
	assign out_valid      = out_valid_q;
	assign pin_level      = pin_q;
	assign pulse_width_us = cur_q;
	assign lid_open       = lid_q;

	`SPWM_ASSERT_NEXT(a_pin_only_on_tick, !(upd && is_tick), $stable(pin_q),
		"pin changed without a tick")
	`SPWM_ASSERT_NEXT(a_ramp_up_no_overshoot, upd && is_tick && (cur_q < tgt_q),
		cur_q <= $past(tgt_q), "ramp overshot target going up")
	`SPWM_ASSERT_NEXT(a_ramp_dn_no_overshoot, upd && is_tick && (cur_q > tgt_q),
		cur_q >= $past(tgt_q), "ramp overshot target going down")
	`SPWM_ASSERT_NEXT(a_width_only_on_tick, !(upd && is_tick), $stable(cur_q),
		"pulse width changed without a tick")

endmodule

// ===== sv/servo_pwm_with_slew_ramp.sv =====
// Top level of the slew-limited RC servo PWM generator.
//
// Items arrive on the input channel (in_valid/in_stall with op, angle,
// humidity): op tick counts one microsecond, op set-angle loads a new
// target width, op humidity may open or close the lid and load its angle.
// Every item gives exactly one result on the output channel (out_valid/
// out_stall with pin_level, pulse_width_us, lid_open) showing the state
// after that item.
// One item is taken per clock unless in_stall is high; the three-stage
// chain is input register, product register and state/result register.
// When the receiver stalls, the result holds and bubbles in the chain close
// up; in_stall rises only once all three stages are full.
// Registers are written through the APB-style port; the user must write
// them only while the block is idle, and the block does not enforce this.
// Reset returns registers and state to their defaults and empties the
// pipeline; it takes effect at once and needs no clearing pass.
`timescale 1ns / 1ps
`include "servo_pwm_with_slew_ramp_macros.svh"
module servo_pwm_with_slew_ramp
	import spwm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [7:0]        angle,
	input  logic [9:0]        humidity,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              pin_level,
	output logic [11:0]       pulse_width_us,
	output logic              lid_open
);

	spwm_cfg_t  cfg;
	spwm_prod_t prod_s2;

	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] angle_s1;
	logic [9:0] humidity_s1;
	logic       adv1, adv2, adv3;

	assign adv3     = !out_valid || !out_stall;
	assign adv2     = !prod_s2.valid || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			op_s1       <= op;
			angle_s1    <= angle;
			humidity_s1 <= humidity;
		end
	end

	spwm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spwm_target u_target (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (adv2),
		.valid_s1    (valid_s1),
		.op_s1       (op_s1),
		.angle_s1    (angle_s1),
		.humidity_s1 (humidity_s1),
		.cfg         (cfg),
		.prod_s2     (prod_s2)
	);

	spwm_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (adv3),
		.prod_s2        (prod_s2),
		.cfg            (cfg),
		.out_valid      (out_valid),
		.pin_level      (pin_level),
		.pulse_width_us (pulse_width_us),
		.lid_open       (lid_open)
	);

	`SPWM_ASSERT_NOW(a_full_backpressure, valid_s1 && prod_s2.valid && out_valid && out_stall,
		in_stall, "full pipeline failed to stall the input")
	`SPWM_ASSERT_NOW(a_bubble_no_stall, !valid_s1, !in_stall,
		"input stalled with an empty input stage")

endmodule
